// ===== src/assert_macros.svh =====
// assertion macros used by the heap queue controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define BHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define BHPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BHPQ_ASSERT(lbl, prop, msg)
`define BHPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/bhpq_pkg.sv =====
// types and codes of the binary min-heap priority queue
package bhpq_pkg;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [15:0]        job_handle;
    logic signed [31:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_job_handle;
    logic signed [31:0] out_priority;
    logic [1:0]         status;
    logic [6:0]         count_after;
  } out_item_t;

  // one heap slot
  typedef struct packed {
    logic [15:0]        handle;
    logic signed [31:0] prio;
  } entry_t;

endpackage

// ===== src/bhpq_mem.sv =====
// heap slot memory: one write port, two registered read ports
module bhpq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  bhpq_pkg::entry_t  wr_data_i,
  input  logic [AW-1:0]     rd_addr_a_i,
  input  logic [AW-1:0]     rd_addr_b_i,
  output bhpq_pkg::entry_t  rd_data_a_o,
  output bhpq_pkg::entry_t  rd_data_b_o
);
  import bhpq_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_a_q;
  entry_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem_q[rd_addr_a_i];
    rd_b_q <= mem_q[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ===== src/bhpq_ctrl.sv =====
// heap sequencer: push sift-up and pop sift-down over the slot memory
`include "assert_macros.svh"

module bhpq_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bhpq_pkg::in_item_t  in_item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output bhpq_pkg::out_item_t res_item_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output bhpq_pkg::entry_t    mem_wdata_o,
  output logic [AW-1:0]       mem_raddr_a_o,
  output logic [AW-1:0]       mem_raddr_b_o,
  input  bhpq_pkg::entry_t    mem_rdata_a_i,
  input  bhpq_pkg::entry_t    mem_rdata_b_i
);
  import bhpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SIFT_UP,
    S_SIFT_DN,
    S_FINISH
  } state_e;

  state_e    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pos_q, pos_d;
  entry_t    mov_q, mov_d;
  out_item_t res_q, res_d;

  logic [AW-1:0] par;
  logic [AW-1:0] tail;
  logic [AW+1:0] lc_w;
  logic [AW+1:0] rc_w;
  logic [AW+1:0] child_w;
  logic [AW:0]   nl_w;
  logic          take_l;
  logic          take_r;
  logic signed [31:0] best_prio;
  entry_t        child_data;
  entry_t        new_entry;
  logic [31:0]   cnt_ext;

  assign new_entry = '{handle: in_item_i.job_handle, prio: in_item_i.priority_req};
  assign par       = (pos_q - AW'(1)) >> 1;
  assign tail      = count_q[AW-1:0] - AW'(1);
  assign lc_w      = {1'b0, pos_q, 1'b1};
  assign rc_w      = lc_w + (AW+2)'(1);

  // child selection: left on ties, only strictly smaller children move up
  always_comb begin
    take_l     = (32'(lc_w) < 32'(count_q)) &&
                 ($signed(mem_rdata_a_i.prio) < $signed(mov_q.prio));
    best_prio  = take_l ? mem_rdata_a_i.prio : mov_q.prio;
    take_r     = (32'(rc_w) < 32'(count_q)) &&
                 ($signed(mem_rdata_b_i.prio) < $signed(best_prio));
    child_w    = take_r ? rc_w : lc_w;
    child_data = take_r ? mem_rdata_b_i : mem_rdata_a_i;
    nl_w       = {child_w[AW-1:0], 1'b1};
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    pos_d         = pos_q;
    mov_d         = mov_q;
    res_d         = res_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = mov_q;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;
    res_valid_o   = 1'b0;
    cnt_ext       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d.out_job_handle = '0;
          res_d.out_priority   = '0;
          res_d.status         = ST_DONE;
          state_d              = S_FINISH;
          if (in_item_i.req_type == REQ_PUSH) begin
            if (count_q == CW'(CAPACITY)) begin
              res_d.status = ST_FULL;
            end else begin
              count_d = count_q + CW'(1);
              mov_d   = new_entry;
              pos_d   = count_q[AW-1:0];
              if (count_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                mem_wdata_o = new_entry;
              end else begin
                mem_raddr_a_o = tail >> 1;
                state_d       = S_SIFT_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              res_d.status = ST_EMPTY;
            end else begin
              count_d       = count_q - CW'(1);
              mem_raddr_a_o = '0;
              mem_raddr_b_o = tail;
              state_d       = S_POP_RD;
            end
          end
          cnt_ext           = 32'(count_d);
          res_d.count_after = cnt_ext[6:0];
        end
      end

      S_POP_RD: begin
        // root goes out, tail becomes the entry sifted down from the root
        res_d.out_job_handle = mem_rdata_a_i.handle;
        res_d.out_priority   = mem_rdata_a_i.prio;
        if (count_q == '0) begin
          state_d = S_FINISH;
        end else begin
          mov_d         = mem_rdata_b_i;
          pos_d         = '0;
          mem_raddr_a_o = AW'(1);
          mem_raddr_b_o = AW'(2);
          state_d       = S_SIFT_DN;
        end
      end

      S_SIFT_UP: begin
        mem_we_o = 1'b1;
        if (pos_q == '0) begin
          state_d = S_FINISH;
        end else if ($signed(mov_q.prio) < $signed(mem_rdata_a_i.prio)) begin
          // parent moves down into the hole
          mem_wdata_o   = mem_rdata_a_i;
          pos_d         = par;
          mem_raddr_a_o = (par - AW'(1)) >> 1;
        end else begin
          state_d = S_FINISH;
        end
      end

      S_SIFT_DN: begin
        mem_we_o = 1'b1;
        if (take_l || take_r) begin
          mem_wdata_o   = child_data;
          pos_d         = child_w[AW-1:0];
          mem_raddr_a_o = nl_w[AW-1:0];
          mem_raddr_b_o = nl_w[AW-1:0] + AW'(1);
        end else begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    mov_q <= mov_d;
    res_q <= res_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign res_item_o = res_q;

  `BHPQ_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
  `BHPQ_ASSERT(a_full_status, res_valid_o && res_q.status == ST_FULL |-> count_q == CW'(CAPACITY), "full status with free slots")
  `BHPQ_ASSERT(a_empty_status, res_valid_o && res_q.status == ST_EMPTY |-> count_q == '0, "empty status with entries held")
  `BHPQ_ASSERT(a_hole_in_heap, state_q == S_SIFT_DN |-> 32'(pos_q) < 32'(count_q), "sift-down hole beyond heap tail")

endmodule

// ===== src/binary_min_heap_priority_queue.sv =====
// Binary min-heap priority queue of job items with a fixed capacity.
// Push sifts the new entry up from the tail, at most $clog2(CAPACITY) - 1 levels.
// Pop returns the root and sifts the tail entry down from it; a pop of the last entry skips the sift.
// Push to an empty heap, push to a full heap and pop on an empty heap go straight to the result.
// One item at a time, the next taken in the cycle after the result enters the output register.
// Reset clears the entry count and handshake state; the slot memory is not cleared.
module binary_min_heap_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bhpq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bhpq_pkg::out_item_t out_item_o
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  entry_t        mem_rdata_a;
  entry_t        mem_rdata_b;

  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;

  logic      out_valid_q;
  out_item_t out_item_q;

  bhpq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i       (clk_i),
    .wr_en_i     (mem_we),
    .wr_addr_i   (mem_waddr),
    .wr_data_i   (mem_wdata),
    .rd_addr_a_i (mem_raddr_a),
    .rd_addr_b_i (mem_raddr_b),
    .rd_data_a_o (mem_rdata_a),
    .rd_data_b_o (mem_rdata_b)
  );

  bhpq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_item_i     (in_item_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_item_o    (res_item),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  // output register frees as its item leaves
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the binary min-heap priority queue
`timescale 1ns / 1ps

module testbench;
  import bhpq_pkg::*;

  localparam int HEAP_CAPACITY = 64;
  localparam int RANDOM_ITEMS  = 800;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 300;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t result;
  } stim_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_TIES} phase_kind_e;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // shadow copy of the heap, advanced once per accepted item
  entry_t      shadow_heap [HEAP_CAPACITY];
  int unsigned shadow_count = 0;

  out_item_t expected_results[$];
  stim_row_t directed_rows[$];
  out_item_t want_item;
  int        error_count    = 0;
  int        cycle_count    = 0;
  int        accepted_items = 0;
  int        burst_left     = 0;
  bit        hold_active    = 1'b0;

  binary_min_heap_priority_queue #(
    .CAPACITY(HEAP_CAPACITY)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    entry_t tmp;
    tmp            = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = tmp;
  endfunction

  function automatic out_item_t predict_heap_request(in_item_t req);
    out_item_t   res;
    int unsigned pos;
    int unsigned up;
    int unsigned lc;
    int unsigned rc;
    int unsigned best;
    res = '0;
    if (req.req_type == REQ_PUSH) begin
      if (shadow_count >= HEAP_CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = shadow_count;
        shadow_heap[pos].handle = req.job_handle;
        shadow_heap[pos].prio   = req.priority_req;
        // climb only while strictly smaller than the parent
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!($signed(shadow_heap[pos].prio) < $signed(shadow_heap[up].prio))) break;
          swap_slots(pos, up);
          pos = up;
        end
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_job_handle = shadow_heap[0].handle;
        res.out_priority   = shadow_heap[0].prio;
        shadow_heap[0]     = shadow_heap[shadow_count - 1];
        shadow_count--;
        pos = 0;
        // left child wins a tie, an equal child stays put
        while (shadow_count > 0) begin
          lc   = 2 * pos + 1;
          rc   = 2 * pos + 2;
          best = pos;
          if (lc < shadow_count &&
              $signed(shadow_heap[lc].prio) < $signed(shadow_heap[best].prio)) best = lc;
          if (rc < shadow_count &&
              $signed(shadow_heap[rc].prio) < $signed(shadow_heap[best].prio)) best = rc;
          if (best == pos) break;
          swap_slots(pos, best);
          pos = best;
        end
      end
    end
    res.count_after = 7'(shadow_count);
    return res;
  endfunction

  function automatic in_item_t push_req(logic [15:0] h, logic [31:0] p);
    in_item_t it;
    it.req_type     = REQ_PUSH;
    it.job_handle   = h;
    it.priority_req = p;
    return it;
  endfunction

  // handle and priority of a pop are don't-care, so they carry junk
  function automatic in_item_t pop_req(logic [15:0] h, logic [31:0] p);
    in_item_t it;
    it.req_type     = REQ_POP;
    it.job_handle   = h;
    it.priority_req = p;
    return it;
  endfunction

  function automatic out_item_t heap_result(logic [15:0] h, logic [31:0] p,
                                            logic [1:0] st, int unsigned cnt);
    out_item_t res;
    res.out_job_handle = h;
    res.out_priority   = p;
    res.status         = st;
    res.count_after    = 7'(cnt);
    return res;
  endfunction

  function automatic void add_row(in_item_t req, bit typed, out_item_t result);
    stim_row_t row;
    row.req    = req;
    row.typed  = typed;
    row.result = result;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [31:0] random_prio(bit ties);
    if (ties) return 32'($urandom_range(0, 3)) - 32'd1;
    case ($urandom_range(0, 9))
      0:          return 32'h8000_0000;
      1:          return 32'h7fff_ffff;
      2, 3, 4, 5: return $urandom();
      default:    return 32'($urandom_range(0, 200)) - 32'd100;
    endcase
  endfunction

  function automatic in_item_t random_push(bit ties);
    return push_req(16'($urandom_range(0, 65535)), random_prio(ties));
  endfunction

  function automatic in_item_t random_pop();
    return pop_req(16'($urandom_range(0, 65535)), $urandom());
  endfunction

  // offers one item in bursts; valid stays high across a burst
  task automatic offer_item(in_item_t req, bit typed, out_item_t result);
    out_item_t predicted;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_heap_request(req);
    expected_results.push_back(typed ? result : predicted);
    accepted_items++;
    burst_left--;
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    burst_left = $urandom_range(1, 16);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected");
        error_count++;
      end else begin
        want_item = expected_results.pop_front();
        check_field("out_job_handle", want_item.out_job_handle, out_item_o.out_job_handle);
        check_field("out_priority", $signed(want_item.out_priority),
                    $signed(out_item_o.out_priority));
        check_field("status", want_item.status, out_item_o.status);
        check_field("count_after", want_item.count_after, out_item_o.count_after);
      end
    end
  end

  // receiver: segments of free flow, light, heavy and periodic stalling
  initial begin : receiver
    int mode;
    int seg_len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_active && accepted_items >= HOLD_AFTER) begin
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 80);
      for (int k = 0; k < seg_len; k++) begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (k % 5 < 2);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    phase_kind_e kind;
    in_item_t    req;
    int          phase;
    int          extra;
    int          total;

    add_row(pop_req(16'h0000, 32'h0000_0000), 1, heap_result(0, 0, ST_EMPTY, 0));
    add_row(pop_req(16'hffff, 32'hffff_ffff), 1, heap_result(0, 0, ST_EMPTY, 0));
    add_row(push_req(16'hffff, 32'h7fff_ffff), 1, heap_result(0, 0, ST_DONE, 1));
    add_row(push_req(16'h0000, 32'h8000_0000), 1, heap_result(0, 0, ST_DONE, 2));
    add_row(pop_req(16'h0000, 32'h0000_0000), 1,
            heap_result(16'h0000, 32'h8000_0000, ST_DONE, 1));
    add_row(pop_req(16'h0000, 32'h0000_0000), 1,
            heap_result(16'hffff, 32'h7fff_ffff, ST_DONE, 0));
    // equal priorities leave in the order that the shadow heap predicts
    for (int h = 1; h <= 6; h++) add_row(push_req(16'(h), 32'd5), 0, '0);
    add_row(push_req(16'd7, 32'd4), 0, '0);
    add_row(push_req(16'd8, 32'd5), 0, '0);
    add_row(push_req(16'd9, 32'hffff_ffff), 0, '0);
    for (int n = 0; n < 9; n++) add_row(pop_req(16'(n), 32'(n)), 0, '0);
    add_row(pop_req(16'h5a5a, 32'h1234_5678), 1, heap_result(0, 0, ST_EMPTY, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);

    total = directed_rows.size() + RANDOM_ITEMS;
    phase = 0;
    while (accepted_items < total) begin
      kind = (phase == 0) ? PH_FILL : phase_kind_e'($urandom_range(0, 3));
      // no pause around the long receiver hold, so the sender keeps pressing
      if ((!hold_active && accepted_items < HOLD_AFTER - 50) ||
          accepted_items > HOLD_AFTER + 100) begin
        if (phase == 1 || $urandom_range(0, 4) == 0) wait_until_drained();
      end
      case (kind)
        PH_FILL: begin
          extra = $urandom_range(1, 3);
          while (extra > 0) begin
            if ($urandom_range(0, 9) == 0) begin
              req = random_pop();
            end else begin
              req = random_push($urandom_range(0, 3) == 0);
              if (shadow_count == HEAP_CAPACITY) extra--;
            end
            offer_item(req, 0, '0);
          end
        end
        PH_DRAIN: begin
          extra = $urandom_range(1, 2);
          while (extra > 0) begin
            if ($urandom_range(0, 9) == 0) begin
              req = random_push(0);
            end else begin
              req = random_pop();
              if (shadow_count == 0) extra--;
            end
            offer_item(req, 0, '0);
          end
        end
        default: begin
          repeat ($urandom_range(20, 60)) begin
            if (kind == PH_TIES)
              req = ($urandom_range(0, 9) < 6) ? random_push(1) : random_pop();
            else
              req = ($urandom_range(0, 1) == 0) ? random_push(0) : random_pop();
            offer_item(req, 0, '0);
          end
        end
      endcase
      phase++;
    end

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
